### hdl/ksvt_pkg.sv
// Shared constants, types and state codes of the keyed sensor value table.
package ksvt_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int TIME_W    = 48;
	localparam int DATA_W    = VAL_W + TIME_W;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	// -999.0 in Q16.16
	localparam logic [VAL_W-1:0] SENTINEL = 32'hFC19_0000;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	// key memory write request, top -> scanner
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [KEY_W-1:0] key;
	} key_wr_t;

	// search outcome, scanner -> top; done pulses when the search ends, the rest is held until the next search starts
	typedef struct packed {
		logic             done;
		logic             match;
		logic [IDX_W-1:0] match_idx;
		logic             match_written;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} scan_res_t;

endpackage

### hdl/ksvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ksvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/ksvt_scan.sv
// Key memory with per-slot written bits and the slot-by-slot key search.
module ksvt_scan
	import ksvt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [KEY_W-1:0] key,
	input  key_wr_t          wr,
	output scan_res_t        res
);

	logic             scan_on_q;
	logic [IDX_W-1:0] cnt_q;
	logic [KEY_W-1:0] key_q;
	logic [NUM_SLOTS-1:0] written_q;

	logic             vld_s1;
	logic             last_s1;
	logic [IDX_W-1:0] addr_s1;

	logic             done_q;
	logic             match_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             match_wr_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic [KEY_W-1:0] ram_key;
	logic [KEY_W-1:0] slot_key;

	ksvt_ram #(
		.WIDTH(KEY_W),
		.DEPTH(NUM_SLOTS)
	) u_key_ram (
		.clk  (clk),
		.we   (wr.en),
		.waddr(wr.idx),
		.wdata(wr.key),
		.re   (scan_on_q),
		.raddr(cnt_q),
		.rdata(ram_key)
	);

	// never-written slots read as empty
	assign slot_key = written_q[addr_s1] ? ram_key : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_on_q <= 1'b0;
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			done_q    <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			written_q <= '0;
		end else begin
			vld_s1  <= scan_on_q;
			last_s1 <= (cnt_q == LAST_IDX);
			done_q  <= vld_s1 && last_s1;

			if (go) begin
				scan_on_q <= 1'b1;
				match_q   <= 1'b0;
				free_q    <= 1'b0;
			end else if (scan_on_q && cnt_q == LAST_IDX) begin
				scan_on_q <= 1'b0;
			end

			if (vld_s1) begin
				if (!match_q && slot_key == key_q) begin
					match_q <= 1'b1;
				end
				if (!free_q && slot_key == '0) begin
					free_q <= 1'b1;
				end
			end

			if (wr.en) begin
				written_q[wr.idx] <= 1'b1;
			end
		end
	end

	// payload side of the search
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (go) begin
			key_q <= key;
			cnt_q <= '0;
		end else if (scan_on_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (vld_s1 && !match_q && slot_key == key_q) begin
			match_idx_q <= addr_s1;
			match_wr_q  <= written_q[addr_s1];
		end
		if (vld_s1 && !free_q && slot_key == '0) begin
			free_idx_q <= addr_s1;
		end
	end

	assign res.done          = done_q;
	assign res.match         = match_q;
	assign res.match_idx     = match_idx_q;
	assign res.match_written = match_wr_q;
	assign res.free          = free_q;
	assign res.free_idx      = free_idx_q;

endmodule

### hdl/keyed_sensor_value_table.sv
// Top level of the keyed sensor value table: command sequencer, value/time memory, result beat.
//
// A table of NUM_SLOTS slots (16), each holding a 32-bit sensor key, a signed
// Q16.16 value and a 48-bit millisecond time; key 0 marks an empty slot and the
// table is empty after reset (per-slot written bits, no clearing pass).
// A command beat is taken when start is high and busy is low. opcode 0 updates:
// the slot holding sensor_key is overwritten, else the first empty slot is
// claimed; with neither, the beat is dropped and table_full is reported.
// opcode 1 reads: on a hit value_out/time_out carry the stored contents, on a
// miss hit is low, value_out is -999.0 (0xFC190000) and time_out is 0.
// Updates always report value_out = -999.0 and time_out = 0.
// Each command produces exactly one result beat, shown for one cycle with done
// high; the receiver cannot stall it, so it must take every beat.
// Timing: the key search walks the key memory one slot per cycle. An update or
// a read miss shows its result once the search has ended; a read hit first
// passes through ST_READ, reading the value/time memory. busy drops in
// the cycle the result is shown, so a new command can be taken then; no new
// command is taken while busy is high. The search reads the key memory
// through its single read port, one slot at a time.
module keyed_sensor_value_table
	import ksvt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [KEY_W-1:0]         sensor_key,
	input  logic signed [VAL_W-1:0]  sample_value,
	input  logic [TIME_W-1:0]        now_ms,
	output logic                     done,
	output logic                     hit,
	output logic                     table_full,
	output logic signed [VAL_W-1:0]  value_out,
	output logic [TIME_W-1:0]        time_out
);

	state_t state_q, state_d;

	// command beat held for the whole search
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [TIME_W-1:0] time_q;

	// result beat
	logic              done_q;
	logic              hit_q;
	logic              full_q;
	logic [VAL_W-1:0]  vout_q;
	logic [TIME_W-1:0] tout_q;

	logic              scan_go;
	scan_res_t         res;
	key_wr_t           key_wr;
	logic [IDX_W-1:0]  slot_idx;
	logic              rd_en;
	logic [DATA_W-1:0] data_rd;

	logic              ld;
	logic              ld_hit;
	logic              ld_full;
	logic [VAL_W-1:0]  ld_val;
	logic [TIME_W-1:0] ld_time;

	ksvt_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (scan_go),
		.key   (sensor_key),
		.wr    (key_wr),
		.res   (res)
	);

	// value and time of each slot, written together with the key.
	// A write lands in the cycle the sequencer returns to idle, so the next
	// search cannot start before both memories hold it: no forwarding needed.
	ksvt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NUM_SLOTS)
	) u_data_ram (
		.clk  (clk),
		.we   (key_wr.en),
		.waddr(slot_idx),
		.wdata({val_q, time_q}),
		.re   (rd_en),
		.raddr(res.match_idx),
		.rdata(data_rd)
	);

	// a matching slot wins over the first empty one
	assign slot_idx = res.match ? res.match_idx : res.free_idx;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (res.done) begin
					state_d = (op_q == OP_READ && res.match) ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		scan_go    = 1'b0;
		key_wr.en  = 1'b0;
		key_wr.idx = slot_idx;
		key_wr.key = key_q;
		rd_en      = 1'b0;
		ld         = 1'b0;
		ld_hit     = 1'b0;
		ld_full    = 1'b0;
		ld_val     = SENTINEL;
		ld_time    = '0;
		unique case (state_q)
			ST_IDLE: begin
				scan_go = start;
			end
			ST_SCAN: begin
				if (res.done) begin
					if (op_q == OP_UPDATE) begin
						key_wr.en = res.match || res.free;
						ld        = 1'b1;
						ld_hit    = res.match || res.free;
						ld_full   = !(res.match || res.free);
					end else if (res.match) begin
						rd_en = 1'b1;
					end else begin
						ld = 1'b1;
					end
				end
			end
			ST_READ: begin
				ld     = 1'b1;
				ld_hit = 1'b1;
				// a slot never written reads as zero
				if (res.match_written) begin
					ld_val  = data_rd[DATA_W-1 -: VAL_W];
					ld_time = data_rd[TIME_W-1:0];
				end else begin
					ld_val  = '0;
					ld_time = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go) begin
			op_q   <= opcode;
			key_q  <= sensor_key;
			val_q  <= sample_value;
			time_q <= now_ms;
		end
		if (ld) begin
			hit_q  <= ld_hit;
			full_q <= ld_full;
			vout_q <= ld_val;
			tout_q <= ld_time;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign hit        = hit_q;
	assign table_full = full_q;
	assign value_out  = $signed(vout_q);
	assign time_out   = tout_q;

endmodule

### dv/keyed_sensor_value_table_test.sv
// Self-checking testbench for the keyed sensor value table: directed and random command beats.
module keyed_sensor_value_table_test;
	import ksvt_pkg::*;

	// no beat in either direction for this many cycles means the block has hung
	localparam int STALL_LIMIT = 1000;
	// cycles to keep watching for stray beats once the last result is in
	localparam int TAIL_CYCLES = 30;

	// one command beat plus the sender's pacing for it
	typedef struct {
		logic                    opcode;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
		logic [TIME_W-1:0]       stamp;
		int                      idle_after;  // cycles start stays low after this beat
		bit                      drain;       // hold this beat until nothing is in flight
	} sensor_cmd_t;

	// one result beat as the block should show it
	typedef struct {
		logic                    hit;
		logic                    full;
		logic signed [VAL_W-1:0] value;
		logic [TIME_W-1:0]       stamp;
	} sensor_reply_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    start        = 1'b0;
	logic                    opcode       = OP_UPDATE;
	logic [KEY_W-1:0]        sensor_key   = '0;
	logic signed [VAL_W-1:0] sample_value = '0;
	logic [TIME_W-1:0]       now_ms       = '0;
	logic                    busy;
	logic                    done;
	logic                    hit;
	logic                    table_full;
	logic signed [VAL_W-1:0] value_out;
	logic [TIME_W-1:0]       time_out;

	keyed_sensor_value_table uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.sensor_key   (sensor_key),
		.sample_value (sample_value),
		.now_ms       (now_ms),
		.done         (done),
		.hit          (hit),
		.table_full   (table_full),
		.value_out    (value_out),
		.time_out     (time_out)
	);

	always #4 clk = ~clk;

	// Shadow copy of the slot table, cleared like the block's after reset.
	logic [KEY_W-1:0]  tbl_key   [NUM_SLOTS];
	logic [VAL_W-1:0]  tbl_value [NUM_SLOTS];
	logic [TIME_W-1:0] tbl_time  [NUM_SLOTS];

	sensor_cmd_t   cmd_queue[$];        // beats still to be sent
	sensor_reply_t pending_replies[$];  // expected result beats, oldest first
	logic [KEY_W-1:0] known_keys[$];    // nonzero keys the stimulus believes are stored

	sensor_cmd_t cur_cmd;
	int idle_left    = 0;
	int accepted_cnt = 0;  // NBA-updated so other blocks see a stable value
	int received_cnt = 0;  // NBA-updated, same reason
	int mismatches   = 0;
	int stall_cycles = 0;
	int n_items      = 0;
	int n_updates    = 0;
	int n_dropped    = 0;
	int n_reads      = 0;
	int n_read_hits  = 0;
	int n_key_zero   = 0;

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tbl_key[i]   = '0;
			tbl_value[i] = '0;
			tbl_time[i]  = '0;
		end
	end

	// First slot, in index order, holding this key; -1 if none.
	// Key 0 is not special here: it finds the first empty slot.
	function automatic int find_slot(logic [KEY_W-1:0] key);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	// Applies one beat to the shadow table and returns the result it must give.
	function automatic sensor_reply_t lookup_or_store(sensor_cmd_t c);
		sensor_reply_t r;
		int idx;
		// defaults: miss, not full, sentinel value, zero time (also the update result)
		r.hit   = 1'b0;
		r.full  = 1'b0;
		r.value = SENTINEL;
		r.stamp = '0;
		idx = find_slot(c.key);
		if (c.opcode == OP_UPDATE) begin
			// no match: claim the first empty slot
			if (idx < 0)
				idx = find_slot('0);
			if (idx >= 0) begin
				tbl_key[idx]   = c.key;
				tbl_value[idx] = c.value;
				tbl_time[idx]  = c.stamp;
				r.hit = 1'b1;
			end else begin
				// neither match nor free slot: dropped, table untouched
				r.full = 1'b1;
			end
		end else if (idx >= 0) begin
			r.hit   = 1'b1;
			r.value = tbl_value[idx];
			r.stamp = tbl_time[idx];
		end
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] rand_stamp();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Queues one beat. The sender idles at random, except in every third stretch
	// of 80 beats where it runs back to back.
	function automatic void add_cmd(logic op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value, logic [TIME_W-1:0] stamp, bit drain);
		sensor_cmd_t c;
		c.opcode     = op;
		c.key        = key;
		c.value      = value;
		c.stamp      = stamp;
		c.drain      = drain;
		c.idle_after = ((cmd_queue.size() / 80) % 3 == 1) ? 0 : $urandom_range(0, 10);
		cmd_queue.push_back(c);
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = $urandom;
		return (k == '0) ? KEY_W'(1) : k;
	endfunction

	function automatic logic [KEY_W-1:0] pick_known();
		return known_keys[$urandom_range(0, known_keys.size() - 1)];
	endfunction

	// Sender: presents beats from cmd_queue, predicts each one as it is taken.
	always @(posedge clk or negedge arst_n) begin : drive
		logic go;
		int inflight;
		sensor_reply_t want;
		if (!arst_n) begin
			start <= 1'b0;
			idle_left = 0;
		end else begin
			go = start;
			inflight = accepted_cnt - received_cnt;
			if (start && !busy) begin
				// beat taken at this edge
				want = lookup_or_store(cur_cmd);
				pending_replies.push_back(want);
				accepted_cnt <= accepted_cnt + 1;
				inflight++;
				if (cur_cmd.key == '0)
					n_key_zero++;
				if (cur_cmd.opcode == OP_UPDATE) begin
					n_updates++;
					if (want.full)
						n_dropped++;
				end else begin
					n_reads++;
					if (want.hit)
						n_read_hits++;
				end
				idle_left = cur_cmd.idle_after;
				go = 1'b0;
			end
			// start is assigned once per edge below, so a back-to-back beat never
			// sees a low-then-high pair in the same step
			if (!go) begin
				if (idle_left > 0)
					idle_left--;
				else if (cmd_queue.size() > 0 && !(cmd_queue[0].drain && inflight > 0)) begin
					cur_cmd = cmd_queue.pop_front();
					opcode       <= cur_cmd.opcode;
					sensor_key   <= cur_cmd.key;
					sample_value <= cur_cmd.value;
					now_ms       <= cur_cmd.stamp;
					go = 1'b1;
				end
			end
			start <= go;
		end
	end

	// Receiver: every done beat must match the oldest expectation.
	always @(posedge clk) begin : check
		sensor_reply_t want;
		if (arst_n && done) begin
			received_cnt <= received_cnt + 1;
			if (pending_replies.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result beat with nothing expected: hit=%b full=%b value=%h time=%h",
						$time, hit, table_full, value_out, time_out);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (hit !== want.hit || table_full !== want.full ||
						value_out !== want.value || time_out !== want.stamp) begin
					if (mismatches < 10)
						$display("%0t: mismatch: want hit=%b full=%b value=%h time=%h, got hit=%b full=%b value=%h time=%h",
							$time, want.hit, want.full, want.value, want.stamp,
							hit, table_full, value_out, time_out);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a beat in either direction resets the count.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d of %0d results in",
					stall_cycles, received_cnt, n_items);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] k;
		int r;

		// Directed part, on an empty table.
		add_cmd(OP_READ,   '0,           $urandom,      rand_stamp(), 0); // key 0 hits empty slot 0
		add_cmd(OP_READ,   32'hFFFF_FFFF, $urandom,     rand_stamp(), 0); // plain miss
		add_cmd(OP_UPDATE, '0,           32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 0); // key 0 write, slot stays empty
		add_cmd(OP_READ,   '0,           $urandom,      rand_stamp(), 1); // sees that write
		add_cmd(OP_UPDATE, 32'hFFFF_FFFF, 32'h8000_0000, '0, 0);         // claims slot 0
		add_cmd(OP_READ,   32'hFFFF_FFFF, $urandom,     rand_stamp(), 0);
		add_cmd(OP_READ,   '0,           $urandom,      rand_stamp(), 0); // now lands on slot 1
		add_cmd(OP_UPDATE, 32'h0000_0001, 32'hFFFF_FFFF, 48'h1, 0);
		add_cmd(OP_UPDATE, 32'hFFFF_FFFF, SENTINEL,     48'h8000_0000_0000, 0); // overwrite
		add_cmd(OP_READ,   32'hFFFF_FFFF, $urandom,     rand_stamp(), 0); // hit carrying the sentinel
		add_cmd(OP_READ,   32'h0000_0001, $urandom,     rand_stamp(), 0);
		add_cmd(OP_READ,   32'h0000_0002, $urandom,     rand_stamp(), 0);
		add_cmd(OP_UPDATE, 32'h8000_0000, '0,           48'h7FFF_FFFF_FFFF, 0);
		add_cmd(OP_READ,   32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
		known_keys = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};

		// Random, table kept short of full: 13 known keys plus key 0 traffic.
		for (int i = 0; i < 10; i++)
			known_keys.push_back(fresh_key());
		for (int i = 0; i < 900; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				add_cmd(OP_UPDATE, pick_known(), $urandom, rand_stamp(), 0);
			else if (r < 85)
				add_cmd(OP_READ, pick_known(), $urandom, rand_stamp(), 0);
			else if (r < 90)
				add_cmd(OP_UPDATE, '0, $urandom, rand_stamp(), 0);
			else if (r < 95)
				add_cmd(OP_READ, '0, $urandom, rand_stamp(), 0);
			else
				add_cmd(OP_READ, fresh_key(), $urandom, rand_stamp(), 0);
		end

		// Let everything drain before the table starts filling.
		add_cmd(OP_READ, known_keys[0], $urandom, rand_stamp(), 1);

		// Random, table filled: new keys take the last free slots, then get dropped.
		for (int i = 0; i < 1000; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				k = fresh_key();
				if (known_keys.size() < NUM_SLOTS)
					known_keys.push_back(k);
				add_cmd(OP_UPDATE, k, $urandom, rand_stamp(), 0);
			end else if (r < 45)
				add_cmd(OP_UPDATE, pick_known(), $urandom, rand_stamp(), r == 13);
			else if (r < 80)
				add_cmd(OP_READ, pick_known(), $urandom, rand_stamp(), 0);
			else if (r < 85)
				add_cmd(OP_UPDATE, '0, $urandom, rand_stamp(), 0);
			else if (r < 90)
				add_cmd(OP_READ, '0, $urandom, rand_stamp(), 0);
			else
				add_cmd(OP_READ, fresh_key(), $urandom, rand_stamp(), 0);
		end
		n_items = cmd_queue.size();

		// reset held low from the start, released once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// one result per beat; the watchdog covers a missing one
		while (received_cnt != n_items)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d updates (%0d dropped as full) and %0d reads (%0d hits), %0d with key 0",
			n_updates, n_dropped, n_reads, n_read_hits, n_key_zero);
		$display("%0d mismatches, %0d expected results never seen",
			mismatches, pending_replies.size());
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
